>>> rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

>>> rtl/hbmt_pkg.sv
`default_nettype none
package hbmt_pkg;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_HEADER = 3'd1,
		OP_ENTRY  = 3'd2,
		OP_FORCE  = 3'd3,
		OP_QUERY  = 3'd4,
		OP_RESET  = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		RK_EVICT  = 2'd0,
		RK_BHEAD  = 2'd1,
		RK_BENTRY = 2'd2,
		RK_QUERY  = 2'd3
	} result_kind_t;

	typedef enum logic [1:0] {
		CFG_OWN       = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_PERIOD    = 2'd2
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD_SCAN,
		ST_POST,
		ST_EXP_SCAN,
		ST_EXP_EMIT,
		ST_EXP_SHIFT,
		ST_BC_HEAD,
		ST_BC_SCAN,
		ST_Q_SCAN,
		ST_Q_EMIT,
		ST_WAIT_OUT
	} state_t;

endpackage
`default_nettype wire

>>> rtl/heartbeat_membership_table_core.sv
// heartbeat membership table
// in channel: one beat per item (opcode, peer_address, clock_value, entry_offset,
// last_of_packet); out channel: result beats, last marks the final beat of an item.
// cfg channel: cfg_index 0 own_address, 1 eviction age limit, 2 broadcast_period;
// write only while idle.
// an item walks the table one entry per cycle through a single compare unit,
// but pauses for each eviction (emit, then shift the later entries down) and
// while a beat cannot load; broadcast sends a header beat before the entries.
// an eviction beat is held back until the next eviction or the end of the scan,
// so the final one can carry last; a wait state sends it after the scan.
// in_ready is low while an item is in work; the next item is taken once the
// last result beat is held in the output register.
// each result beat waits in the output register while out_ready is low; a
// step that must load another beat stalls until that beat is taken.
// reset clears count, local clock, tick counter, header clock and pending flag;
// table contents are not cleared.
`default_nettype none
module heartbeat_membership_table_core #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  opcode,
	input  wire  [15:0] peer_address,
	input  wire  [31:0] clock_value,
	input  wire  [7:0]  entry_offset,
	input  wire         last_of_packet,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  result_kind,
	output logic [15:0] member_address,
	output logic [31:0] clock_out,
	output logic [7:0]  offset_out,
	output logic        alive,
	output logic        last,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
`include "assert_macros.svh"

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	hbmt_pkg::state_t state_q, state_d;

	logic [15:0] addr_mem [TABLE_DEPTH];
	logic [31:0] clk_mem  [TABLE_DEPTH];

	logic [15:0] own_q;
	logic [31:0] thr_q;
	logic [15:0] per_q;
	logic [CW-1:0] count_q;
	logic [31:0] time_q, hclk_q;
	logic [15:0] tick_q;
	logic pend_q;

	logic [CW-1:0] idx_q;
	logic [2:0]  op_q;
	logic [15:0] addr_q;
	logic [31:0] val_q;
	logic        lastp_q, found_q, bcast_q;
	logic [15:0] ev_addr_q;
	logic [CW-1:0] ev_idx_q;

	logic [15:0] rd_addr;
	logic [31:0] rd_clk, age;
	logic        in_range;
	logic        out_free;
	logic        post_new, post_expire;
	logic        out_load;

	assign in_range = idx_q < count_q;
	assign rd_addr  = addr_mem[idx_q[IW-1:0]];
	assign rd_clk   = clk_mem[idx_q[IW-1:0]];
	assign age      = time_q + 32'd1 - rd_clk;
	assign out_free = !out_valid || out_ready;

	assign post_new = op_q == hbmt_pkg::OP_ENTRY && addr_q != own_q
		&& val_q > time_q + 32'd1;
	assign post_expire = lastp_q && op_q != hbmt_pkg::OP_FORCE && (post_new || pend_q);

	assign in_ready  = state_q == hbmt_pkg::ST_IDLE;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hbmt_pkg::ST_IDLE:
				if (in_valid && in_ready) begin
					unique case (opcode)
						hbmt_pkg::OP_TICK: state_d = hbmt_pkg::ST_EXP_SCAN;
						hbmt_pkg::OP_HEADER, hbmt_pkg::OP_ENTRY, hbmt_pkg::OP_FORCE:
							state_d = hbmt_pkg::ST_UPD_SCAN;
						hbmt_pkg::OP_QUERY: state_d = hbmt_pkg::ST_Q_SCAN;
						default: state_d = hbmt_pkg::ST_IDLE;
					endcase
				end
			hbmt_pkg::ST_UPD_SCAN:
				if (!in_range || rd_addr == addr_q) state_d = hbmt_pkg::ST_POST;
			hbmt_pkg::ST_POST:
				state_d = post_expire ? hbmt_pkg::ST_EXP_SCAN : hbmt_pkg::ST_IDLE;
			hbmt_pkg::ST_EXP_SCAN:
				if (!in_range) begin
					if (hold_q) state_d = hbmt_pkg::ST_WAIT_OUT;
					else if (bcast_q) state_d = hbmt_pkg::ST_BC_HEAD;
					else state_d = hbmt_pkg::ST_IDLE;
				end else if (age >= thr_q) state_d = hbmt_pkg::ST_EXP_EMIT;
			hbmt_pkg::ST_EXP_EMIT:
				if (!hold_q || out_free) state_d = hbmt_pkg::ST_EXP_SHIFT;
			hbmt_pkg::ST_EXP_SHIFT:
				if (!(idx_q + CW'(1) < count_q)) state_d = hbmt_pkg::ST_EXP_SCAN;
			hbmt_pkg::ST_BC_HEAD:
				if (out_free) state_d = hbmt_pkg::ST_BC_SCAN;
			hbmt_pkg::ST_BC_SCAN:
				if (!in_range) state_d = hbmt_pkg::ST_IDLE;
			hbmt_pkg::ST_Q_SCAN:
				if (!in_range) state_d = hbmt_pkg::ST_Q_EMIT;
			hbmt_pkg::ST_Q_EMIT:
				if (out_free) state_d = hbmt_pkg::ST_IDLE;
			hbmt_pkg::ST_WAIT_OUT:
				if (out_free) state_d = bcast_q ? hbmt_pkg::ST_BC_HEAD : hbmt_pkg::ST_IDLE;
			default: state_d = hbmt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		out_load = 1'b0;
		unique case (state_q)
			hbmt_pkg::ST_EXP_EMIT: out_load = hold_q && out_free;
			hbmt_pkg::ST_WAIT_OUT, hbmt_pkg::ST_BC_HEAD, hbmt_pkg::ST_Q_EMIT:
				out_load = out_free;
			hbmt_pkg::ST_BC_SCAN: out_load = in_range && out_free;
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hbmt_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// an eviction beat is waiting in ev_addr_q
	logic hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q     <= '0;
			thr_q     <= '0;
			per_q     <= 16'd1;
			count_q   <= '0;
			time_q    <= '0;
			hclk_q    <= '0;
			tick_q    <= '0;
			pend_q    <= 1'b0;
			out_valid <= 1'b0;
			hold_q    <= 1'b0;
			idx_q     <= '0;
			bcast_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hbmt_pkg::CFG_OWN:       own_q <= cfg_data[15:0];
					hbmt_pkg::CFG_THRESHOLD: thr_q <= cfg_data;
					hbmt_pkg::CFG_PERIOD:    per_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				hbmt_pkg::ST_IDLE:
					if (in_valid && in_ready) begin
						idx_q    <= '0;
						bcast_q  <= 1'b0;
						hold_q   <= 1'b0;
						found_q  <= 1'b0;
						unique case (opcode)
							hbmt_pkg::OP_TICK: begin
								time_q <= time_q + 32'd1;
								if (tick_q + 16'd1 == per_q) begin
									tick_q  <= '0;
									bcast_q <= 1'b1;
								end else tick_q <= tick_q + 16'd1;
							end
							hbmt_pkg::OP_HEADER: begin
								hclk_q <= clock_value;
								pend_q <= clock_value > time_q + 32'd1;
								if (clock_value > time_q + 32'd1) time_q <= clock_value;
							end
							hbmt_pkg::OP_RESET: begin
								time_q  <= thr_q;
								count_q <= '0;
								pend_q  <= 1'b0;
							end
							default: ;
						endcase
					end
				hbmt_pkg::ST_UPD_SCAN:
					if (in_range && rd_addr == addr_q) begin
						if (!(op_q == hbmt_pkg::OP_ENTRY && addr_q == own_q)
							&& rd_clk < val_q) clk_mem[idx_q[IW-1:0]] <= val_q;
					end else if (!in_range) begin
						if (!(op_q == hbmt_pkg::OP_ENTRY && addr_q == own_q)
							&& count_q < CW'(TABLE_DEPTH)) begin
							addr_mem[count_q[IW-1:0]] <= addr_q;
							clk_mem[count_q[IW-1:0]]  <= val_q;
							count_q <= count_q + CW'(1);
						end
					end else idx_q <= idx_q + CW'(1);
				hbmt_pkg::ST_POST: begin
					idx_q <= '0;
					if (post_new) time_q <= val_q;
					if (op_q != hbmt_pkg::OP_FORCE && lastp_q) pend_q <= 1'b0;
					else if (post_new) pend_q <= 1'b1;
				end
				hbmt_pkg::ST_EXP_SCAN:
					if (!in_range) idx_q <= '0;
					else if (!(age >= thr_q)) idx_q <= idx_q + CW'(1);
				hbmt_pkg::ST_EXP_EMIT:
					if (!hold_q || out_free) begin
						if (hold_q) begin
							result_kind    <= hbmt_pkg::RK_EVICT;
							member_address <= ev_addr_q;
							clock_out      <= '0;
							offset_out     <= '0;
							alive          <= 1'b0;
							last           <= 1'b0;
						end
						ev_addr_q <= rd_addr;
						ev_idx_q  <= idx_q;
						hold_q    <= 1'b1;
					end
				hbmt_pkg::ST_EXP_SHIFT:
					if (idx_q + CW'(1) < count_q) begin
						addr_mem[idx_q[IW-1:0]] <= addr_mem[IW'(idx_q + CW'(1))];
						clk_mem[idx_q[IW-1:0]]  <= clk_mem[IW'(idx_q + CW'(1))];
						idx_q <= idx_q + CW'(1);
					end else begin
						count_q <= count_q - CW'(1);
						idx_q   <= ev_idx_q;
					end
				hbmt_pkg::ST_BC_HEAD:
					if (out_free) begin
						result_kind    <= hbmt_pkg::RK_BHEAD;
						member_address <= own_q;
						clock_out      <= time_q;
						offset_out     <= '0;
						alive          <= 1'b0;
						last           <= count_q == '0;
					end
				hbmt_pkg::ST_BC_SCAN:
					if (in_range && out_free) begin
						result_kind    <= hbmt_pkg::RK_BENTRY;
						member_address <= rd_addr;
						clock_out      <= '0;
						offset_out     <= age[7:0];
						alive          <= 1'b0;
						last           <= idx_q + CW'(1) == count_q;
						idx_q          <= idx_q + CW'(1);
					end
				hbmt_pkg::ST_Q_SCAN:
					if (in_range) begin
						if (rd_addr == addr_q) found_q <= 1'b1;
						idx_q <= idx_q + CW'(1);
					end
				hbmt_pkg::ST_Q_EMIT:
					if (out_free) begin
						result_kind    <= hbmt_pkg::RK_QUERY;
						member_address <= addr_q;
						clock_out      <= '0;
						offset_out     <= '0;
						alive          <= found_q || addr_q == own_q;
						last           <= 1'b1;
					end
				hbmt_pkg::ST_WAIT_OUT:
					if (out_free) begin
						result_kind    <= hbmt_pkg::RK_EVICT;
						member_address <= ev_addr_q;
						clock_out      <= '0;
						offset_out     <= '0;
						alive          <= 1'b0;
						last           <= !bcast_q;
						hold_q         <= 1'b0;
					end
				default: ;
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (state_q == hbmt_pkg::ST_IDLE && in_valid && in_ready) begin
			op_q    <= opcode;
			addr_q  <= peer_address;
			lastp_q <= last_of_packet;
			unique case (opcode)
				hbmt_pkg::OP_HEADER: val_q <= clock_value;
				hbmt_pkg::OP_ENTRY:  val_q <= hclk_q + 32'd1 - {24'd0, entry_offset};
				default:             val_q <= time_q;
			endcase
		end
	end

	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(TABLE_DEPTH))
	`ASSERT_IMPLIES(a_busy_not_ready, clk, arst_n,
		state_q != hbmt_pkg::ST_IDLE, !in_ready)
	`ASSERT_NEXT(a_query_emits, clk, arst_n,
		state_q == hbmt_pkg::ST_Q_EMIT && out_free,
		out_valid && last && result_kind == hbmt_pkg::RK_QUERY)

endmodule
`default_nettype wire

>>> test/hbmt_checker.sv
module hbmt_checker #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire  [2:0]  opcode,
	input  wire  [15:0] peer_address,
	input  wire  [31:0] clock_value,
	input  wire  [7:0]  entry_offset,
	input  wire         last_of_packet,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [1:0]  result_kind,
	input  wire  [15:0] member_address,
	input  wire  [31:0] clock_out,
	input  wire  [7:0]  offset_out,
	input  wire         alive,
	input  wire         last,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data,
	output int          fails,
	output int          outstanding,
	output logic [31:0] now,
	output int          result_beats,
	output int          evictions,
	output int          broadcasts
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		hbmt_pkg::result_kind_t kind;
		logic [15:0]  addr;
		logic [31:0]  clk_val;
		logic [7:0]   off;
		logic         alive;
		logic         last;
	} beat_t;

	beat_t       expected_beats[$];
	logic [15:0] own_addr;
	logic [31:0] threshold;
	logic [15:0] period;
	logic [15:0] tbl_addr [TABLE_DEPTH];
	logic [31:0] tbl_clk [TABLE_DEPTH];
	int          members;
	logic [31:0] local_clk;
	logic [15:0] tick_cnt;
	logic [31:0] hdr_clk;
	logic        pending;

	task automatic add_beat(hbmt_pkg::result_kind_t k, logic [15:0] a, logic [31:0] c,
			logic [7:0] o, logic al);
		beat_t b;
		b.kind = k;
		b.addr = a;
		b.clk_val = c;
		b.off = o;
		b.alive = al;
		b.last = 1'b0;
		expected_beats.push_back(b);
	endtask

	task automatic refresh_member(logic [15:0] a, logic [31:0] c);
		for (int i = 0; i < members; i++) begin
			if (tbl_addr[i] == a) begin
				if (tbl_clk[i] < c)
					tbl_clk[i] = c;
				return;
			end
		end
		if (members < TABLE_DEPTH) begin
			tbl_addr[members] = a;
			tbl_clk[members] = c;
			members++;
		end
	endtask

	task automatic evict_stale();
		logic [31:0] age;
		int i;
		i = 0;
		while (i < members) begin
			age = local_clk + 32'd1 - tbl_clk[i];
			if (age < threshold) begin
				i++;
			end else begin
				add_beat(hbmt_pkg::RK_EVICT, tbl_addr[i], '0, '0, 1'b0);
				for (int j = i + 1; j < members; j++) begin
					tbl_addr[j-1] = tbl_addr[j];
					tbl_clk[j-1] = tbl_clk[j];
				end
				members--;
			end
		end
	endtask

	task automatic note_remote(logic [31:0] c);
		if (c > local_clk + 32'd1) begin
			pending = 1'b1;
			local_clk = c;
		end
	endtask

	task automatic predict_item();
		int before_n;
		logic hit;
		logic [31:0] rc;
		before_n = expected_beats.size();
		case (hbmt_pkg::opcode_t'(opcode))
			hbmt_pkg::OP_TICK: begin
				local_clk++;
				tick_cnt++;
				evict_stale();
				if (tick_cnt == period) begin
					tick_cnt = '0;
					add_beat(hbmt_pkg::RK_BHEAD, own_addr, local_clk, '0, 1'b0);
					for (int i = 0; i < members; i++)
						add_beat(hbmt_pkg::RK_BENTRY, tbl_addr[i], '0,
							8'(local_clk + 32'd1 - tbl_clk[i]), 1'b0);
				end
			end
			hbmt_pkg::OP_HEADER, hbmt_pkg::OP_ENTRY: begin
				if (hbmt_pkg::opcode_t'(opcode) == hbmt_pkg::OP_HEADER) begin
					hdr_clk = clock_value;
					pending = 1'b0;
					note_remote(clock_value);
					refresh_member(peer_address, clock_value);
				end else if (peer_address != own_addr) begin
					rc = hdr_clk + 32'd1 - {24'd0, entry_offset};
					refresh_member(peer_address, rc);
					note_remote(rc);
				end
				if (last_of_packet) begin
					if (pending)
						evict_stale();
					pending = 1'b0;
				end
			end
			hbmt_pkg::OP_FORCE: refresh_member(peer_address, local_clk);
			hbmt_pkg::OP_QUERY: begin
				hit = (peer_address == own_addr);
				for (int i = 0; i < members; i++)
					if (tbl_addr[i] == peer_address)
						hit = 1'b1;
				add_beat(hbmt_pkg::RK_QUERY, peer_address, '0, '0, hit);
			end
			hbmt_pkg::OP_RESET: begin
				local_clk = threshold;
				members = 0;
				pending = 1'b0;
			end
			default: ;
		endcase
		if (expected_beats.size() > before_n)
			expected_beats[expected_beats.size()-1].last = 1'b1;
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	task automatic check_beat();
		beat_t e;
		if (expected_beats.size() == 0) begin
			$display("%0t: unexpected result beat kind %0d addr %0h", $time,
				result_kind, member_address);
			fails++;
			return;
		end
		e = expected_beats.pop_front();
		check_field("result_kind", 32'(e.kind), 32'(result_kind));
		check_field("member_address", 32'(e.addr), 32'(member_address));
		check_field("clock_out", e.clk_val, clock_out);
		check_field("offset_out", 32'(e.off), 32'(offset_out));
		check_field("alive", 32'(e.alive), 32'(alive));
		check_field("last", 32'(e.last), 32'(last));
		result_beats++;
		if (e.kind == hbmt_pkg::RK_EVICT)
			evictions++;
		if (e.kind == hbmt_pkg::RK_BHEAD)
			broadcasts++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr = '0;
			threshold = '0;
			period = 16'd1;
			members = 0;
			local_clk = '0;
			tick_cnt = '0;
			hdr_clk = '0;
			pending = 1'b0;
			fails = 0;
			result_beats = 0;
			evictions = 0;
			broadcasts = 0;
			expected_beats.delete();
		end else begin
			if (out_valid && out_ready)
				check_beat();
			if (cfg_valid && cfg_ready) begin
				case (hbmt_pkg::cfg_index_t'(cfg_index))
					hbmt_pkg::CFG_OWN:       own_addr = cfg_data[15:0];
					hbmt_pkg::CFG_THRESHOLD: threshold = cfg_data;
					hbmt_pkg::CFG_PERIOD:    period = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_item();
		end
		outstanding = expected_beats.size();
		now = local_clk;
	end

	final begin
		if (expected_beats.size() != 0)
			$display("%0d result beats never arrived", expected_beats.size());
	end
endmodule

>>> test/heartbeat_membership_table_core_tb.sv
module heartbeat_membership_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  opcode;
	logic [15:0] peer_address;
	logic [31:0] clock_value;
	logic [7:0]  entry_offset;
	logic        last_of_packet;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  result_kind;
	logic [15:0] member_address;
	logic [31:0] clock_out;
	logic [7:0]  offset_out;
	logic        alive;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int          fails;
	int          outstanding;
	logic [31:0] now;
	int          result_beats;
	int          evictions;
	int          broadcasts;
	int          send_idle;
	int          recv_idle;
	int          items_sent;
	int          quiet_cycles = 0;
	logic [15:0] cur_own;

	heartbeat_membership_table_core u_dut (.*);

	hbmt_checker u_checker (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(hbmt_pkg::opcode_t op, logic [15:0] a, logic [31:0] c,
			logic [7:0] o, logic lp);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		opcode = op;
		peer_address = a;
		clock_value = c;
		entry_offset = o;
		last_of_packet = lp;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (op <= hbmt_pkg::OP_RESET)
			items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(hbmt_pkg::cfg_index_t idx, logic [31:0] d);
		drain();
		repeat (60) @(posedge clk);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == hbmt_pkg::CFG_OWN)
			cur_own = d[15:0];
	endtask

	function automatic logic [15:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'($urandom);
		if (r < 16)
			return cur_own;
		return 16'h0100 + 16'($urandom_range(0, 19));
	endfunction

	function automatic logic [31:0] pick_clock();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return now + 32'($urandom_range(0, 14)) - 32'd4;
	endfunction

	function automatic logic [7:0] pick_offset();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom);
		return 8'($urandom_range(0, 8));
	endfunction

	task automatic random_traffic(int count);
		int goal;
		int r;
		int n_entries;
		logic broken;
		goal = items_sent + count;
		while (items_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 42) begin
				n_entries = $urandom_range(0, 5);
				broken = ($urandom_range(0, 9) == 0);
				send(hbmt_pkg::OP_HEADER, pick_addr(), pick_clock(), 8'($urandom),
					(n_entries == 0) && !broken);
				for (int i = 0; i < n_entries; i++)
					send(hbmt_pkg::OP_ENTRY, pick_addr(), $urandom, pick_offset(),
						(i == n_entries - 1) && !broken);
			end else if (r < 68) begin
				send(hbmt_pkg::OP_TICK, 16'($urandom), $urandom, 8'($urandom),
					1'($urandom));
			end else if (r < 78) begin
				send(hbmt_pkg::OP_FORCE, pick_addr(), $urandom, 8'($urandom),
					1'($urandom));
			end else if (r < 90) begin
				send(hbmt_pkg::OP_QUERY, pick_addr(), $urandom, 8'($urandom),
					1'($urandom));
			end else if (r < 93) begin
				send(hbmt_pkg::OP_RESET, 16'($urandom), $urandom, 8'($urandom),
					1'($urandom));
			end else if (r < 95) begin
				send(hbmt_pkg::opcode_t'($urandom_range(6, 7)), 16'($urandom), $urandom,
					8'($urandom), 1'($urandom));
			end else if (r < 97) begin
				send(hbmt_pkg::OP_ENTRY, pick_addr(), $urandom, pick_offset(), 1'b1);
			end else begin
				drain();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = hbmt_pkg::OP_TICK;
		peer_address = '0;
		clock_value = '0;
		entry_offset = '0;
		last_of_packet = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = hbmt_pkg::CFG_OWN;
		cfg_data = '0;
		send_idle = 0;
		recv_idle = 0;
		items_sent = 0;
		cur_own = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(hbmt_pkg::CFG_OWN, 32'h1234);
		write_reg(hbmt_pkg::CFG_THRESHOLD, 32'd40);
		write_reg(hbmt_pkg::CFG_PERIOD, 32'd3);

		// directed
		send(hbmt_pkg::OP_QUERY, 16'h1234, '0, '0, 1'b0);
		send(hbmt_pkg::OP_QUERY, 16'h0000, '0, '0, 1'b0);
		send(hbmt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send(hbmt_pkg::OP_ENTRY, 16'h0007, '0, 8'd0, 1'b1);
		send(hbmt_pkg::OP_HEADER, 16'h0001, 32'd10, '0, 1'b0);
		send(hbmt_pkg::OP_ENTRY, 16'h0002, '0, 8'd0, 1'b0);
		send(hbmt_pkg::OP_ENTRY, 16'h0003, '0, 8'd255, 1'b0);
		send(hbmt_pkg::OP_ENTRY, 16'h1234, '0, 8'd1, 1'b0);
		send(hbmt_pkg::OP_ENTRY, 16'h0000, '0, 8'd1, 1'b1);
		send(hbmt_pkg::OP_FORCE, 16'hFFFF, '0, '0, 1'b0);
		send(hbmt_pkg::OP_QUERY, 16'hFFFF, '0, '0, 1'b0);
		send(hbmt_pkg::opcode_t'(3'd6), 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send(hbmt_pkg::opcode_t'(3'd7), '0, '0, '0, 1'b0);
		send(hbmt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send(hbmt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send(hbmt_pkg::OP_HEADER, 16'hABCD, 32'd200, '0, 1'b1);
		send(hbmt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send(hbmt_pkg::OP_RESET, '0, '0, '0, 1'b0);
		send(hbmt_pkg::OP_QUERY, 16'hABCD, '0, '0, 1'b0);
		send(hbmt_pkg::OP_HEADER, 16'h0005, 32'hFFFF_FFFF, '0, 1'b1);
		send(hbmt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send(hbmt_pkg::OP_TICK, '0, '0, '0, 1'b0);

		send_idle = 22;
		recv_idle = 58;
		write_reg(hbmt_pkg::CFG_OWN, 32'($urandom_range(0, 65535)));
		write_reg(hbmt_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
		write_reg(hbmt_pkg::CFG_PERIOD, 32'd1);
		random_traffic(50);

		send_idle = 58;
		recv_idle = 22;
		write_reg(hbmt_pkg::CFG_OWN, 32'hFFFF);
		write_reg(hbmt_pkg::CFG_THRESHOLD, 32'd0);
		write_reg(hbmt_pkg::CFG_PERIOD, 32'd65535);
		random_traffic(15);
		write_reg(hbmt_pkg::CFG_THRESHOLD, 32'd25);
		write_reg(hbmt_pkg::CFG_PERIOD, 32'd2);
		random_traffic(35);

		send_idle = 0;
		recv_idle = 0;
		write_reg(hbmt_pkg::CFG_OWN, 32'd0);
		write_reg(hbmt_pkg::CFG_THRESHOLD, 32'd60);
		write_reg(hbmt_pkg::CFG_PERIOD, 32'd5);
		random_traffic(50);

		drain();
		repeat (60) @(posedge clk);
		$display("Sent %0d items under five register settings and three idle patterns;",
			items_sent);
		$display("checked %0d result beats, %0d evictions, %0d broadcasts.",
			result_beats, evictions, broadcasts);
		if (fails == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
